[rtl/ipv4fp_pkg.sv]
// Shared constants, result kinds and control/status types for the IPv4 fragment planner.
package ipv4fp_pkg;

    localparam int MAX_FRAGMENTS = 64;
    localparam int PORT_BITS     = 4;
    localparam int PCNT_W        = PORT_BITS + 1;
    localparam int LEN_W         = 16;
    localparam int HDR_W         = 6;
    localparam int KIND_W        = 3;
    localparam int PROD_W        = LEN_W + 7;

    localparam logic [PCNT_W-1:0] PORT_COUNT_RST = PCNT_W'(4);
    localparam logic [PROD_W-1:0] FRAG_MULT      = PROD_W'(MAX_FRAGMENTS);

    // input tdata layout
    localparam int IN_DATA_W = 48;
    localparam int IN_TOT_LO = 0;
    localparam int IN_HDR_LO = IN_TOT_LO + LEN_W;
    localparam int IN_MTU_LO = IN_HDR_LO + HDR_W;
    localparam int IN_DF_BIT = IN_MTU_LO + LEN_W;
    localparam int IN_MF_BIT = IN_DF_BIT + 1;
    localparam int IN_PRT_LO = IN_MF_BIT + 1;

    // output tdata layout
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USED_W = 2 * LEN_W + 2 + PORT_BITS;

    localparam logic [KIND_W-1:0] KIND_WHOLE   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FRAG    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ICMP    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BADPORT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BADSIZE = 3'd4;

    typedef struct packed {
        logic              load;
        logic              single;
        logic              start;
        logic              advance;
        logic [KIND_W-1:0] kind;
    } t_cmd;

    typedef struct packed {
        logic fits;
        logic mtu_low;
        logic df;
        logic too_many;
        logic port_ok;
        logic out_last;
    } t_status;

endpackage

[rtl/ipv4fp_ctrl.sv]
// Controller: accepts a header, classifies it and sequences the result transfers.
module ipv4fp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_valid,
    output logic               o_s_ready,
    output logic               o_m_valid,
    input  logic               i_m_ready,
    input  ipv4fp_pkg::t_status i_status,
    output ipv4fp_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = (r_state == S_OUT);

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.kind    = ipv4fp_pkg::KIND_WHOLE;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_OUT;
                // priority follows the datagram checks: fit, size, DF, count, port
                if (i_status.fits) begin
                    o_cmd.single = 1'b1;
                    o_cmd.kind   = i_status.port_ok ? ipv4fp_pkg::KIND_WHOLE
                                                    : ipv4fp_pkg::KIND_BADPORT;
                end else if (i_status.mtu_low) begin
                    o_cmd.single = 1'b1;
                    o_cmd.kind   = ipv4fp_pkg::KIND_BADSIZE;
                end else if (i_status.df) begin
                    o_cmd.single = 1'b1;
                    o_cmd.kind   = ipv4fp_pkg::KIND_ICMP;
                end else if (i_status.too_many) begin
                    o_cmd.single = 1'b1;
                    o_cmd.kind   = ipv4fp_pkg::KIND_BADSIZE;
                end else if (!i_status.port_ok) begin
                    o_cmd.single = 1'b1;
                    o_cmd.kind   = ipv4fp_pkg::KIND_BADPORT;
                end else begin
                    o_cmd.start = 1'b1;
                    o_cmd.kind  = ipv4fp_pkg::KIND_FRAG;
                end
            end
            S_OUT: begin
                if (i_m_ready) begin
                    if (i_status.out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.advance = 1'b1;
                        o_cmd.kind    = ipv4fp_pkg::KIND_FRAG;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/ipv4fp_dp.sv]
// Datapath: header registers, size checks, fragment offset walk and result registers.
module ipv4fp_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ipv4fp_pkg::t_cmd                    i_cmd,
    output ipv4fp_pkg::t_status                 o_status,
    input  logic                                i_cfg_wr_en,
    input  logic [ipv4fp_pkg::PCNT_W-1:0]       i_cfg_wr_data,
    input  logic [ipv4fp_pkg::LEN_W-1:0]        i_datagram_length,
    input  logic [ipv4fp_pkg::HDR_W-1:0]        i_header_length,
    input  logic [ipv4fp_pkg::LEN_W-1:0]        i_link_mtu,
    input  logic                                i_dont_fragment,
    input  logic                                i_more_fragments_in,
    input  logic [ipv4fp_pkg::PORT_BITS-1:0]    i_egress_port,
    output logic [ipv4fp_pkg::KIND_W-1:0]       o_kind,
    output logic [ipv4fp_pkg::LEN_W-1:0]        o_frag_length,
    output logic [ipv4fp_pkg::LEN_W-1:0]        o_frag_offset,
    output logic                                o_more_fragments_out,
    output logic                                o_final_mark,
    output logic [ipv4fp_pkg::PORT_BITS-1:0]    o_out_port,
    output logic                                o_last
);

    logic [ipv4fp_pkg::PCNT_W-1:0]    r_port_count;
    logic [ipv4fp_pkg::LEN_W-1:0]     r_total;
    logic [ipv4fp_pkg::HDR_W-1:0]     r_hdr;
    logic [ipv4fp_pkg::LEN_W-1:0]     r_mtu;
    logic                             r_df;
    logic                             r_mfin;
    logic [ipv4fp_pkg::PORT_BITS-1:0] r_port;
    logic [ipv4fp_pkg::LEN_W-1:0]     r_step;
    logic [ipv4fp_pkg::LEN_W-1:0]     r_payload;
    logic [ipv4fp_pkg::LEN_W-1:0]     r_rem;
    logic [ipv4fp_pkg::LEN_W-1:0]     r_off;

    logic [ipv4fp_pkg::KIND_W-1:0]    r_kind;
    logic [ipv4fp_pkg::LEN_W-1:0]     r_len;
    logic [ipv4fp_pkg::LEN_W-1:0]     r_offo;
    logic                             r_mf;
    logic                             r_fin;
    logic [ipv4fp_pkg::PORT_BITS-1:0] r_oport;
    logic                             r_last;

    logic [ipv4fp_pkg::LEN_W-1:0]     n_rem;
    logic [ipv4fp_pkg::LEN_W-1:0]     n_off;
    logic                             frag_last;
    logic [ipv4fp_pkg::PROD_W-1:0]    step_cap;

    assign step_cap = {{(ipv4fp_pkg::PROD_W - ipv4fp_pkg::LEN_W){1'b0}}, r_step}
                      * ipv4fp_pkg::FRAG_MULT;

    assign o_status.fits     = (r_total <= r_mtu);
    assign o_status.mtu_low  = (r_mtu <= {{(ipv4fp_pkg::LEN_W - ipv4fp_pkg::HDR_W){1'b0}}, r_hdr});
    assign o_status.df       = r_df;
    // n > MAX_FRAGMENTS exactly when payload exceeds MAX_FRAGMENTS * step
    assign o_status.too_many = ({{(ipv4fp_pkg::PROD_W - ipv4fp_pkg::LEN_W){1'b0}}, r_payload}
                                > step_cap);
    assign o_status.port_ok  = ({1'b0, r_port} < r_port_count);
    assign o_status.out_last = r_last;

    // remaining payload from this fragment on; the last one holds at most one step
    always_comb begin
        n_rem     = i_cmd.start ? r_payload : (r_rem - r_step);
        n_off     = i_cmd.start ? '0 : (r_off + r_step);
        frag_last = (n_rem <= r_step);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_count <= ipv4fp_pkg::PORT_COUNT_RST;
        end else if (i_cfg_wr_en) begin
            r_port_count <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_total   <= i_datagram_length;
            r_hdr     <= i_header_length;
            r_mtu     <= i_link_mtu;
            r_df      <= i_dont_fragment;
            r_mfin    <= i_more_fragments_in;
            r_port    <= i_egress_port;
            r_step    <= i_link_mtu
                         - {{(ipv4fp_pkg::LEN_W - ipv4fp_pkg::HDR_W){1'b0}}, i_header_length};
            r_payload <= i_datagram_length
                         - {{(ipv4fp_pkg::LEN_W - ipv4fp_pkg::HDR_W){1'b0}}, i_header_length};
        end
        if (i_cmd.single) begin
            r_kind  <= i_cmd.kind;
            r_len   <= r_total;
            r_offo  <= '0;
            r_mf    <= (i_cmd.kind == ipv4fp_pkg::KIND_WHOLE) & r_mfin;
            r_fin   <= (i_cmd.kind == ipv4fp_pkg::KIND_WHOLE);
            r_oport <= (i_cmd.kind == ipv4fp_pkg::KIND_ICMP) ? '0 : r_port;
            r_last  <= 1'b1;
        end else if (i_cmd.start || i_cmd.advance) begin
            r_rem   <= n_rem;
            r_off   <= n_off;
            r_kind  <= ipv4fp_pkg::KIND_FRAG;
            r_len   <= frag_last
                       ? (n_rem + {{(ipv4fp_pkg::LEN_W - ipv4fp_pkg::HDR_W){1'b0}}, r_hdr})
                       : r_mtu;
            r_offo  <= n_off;
            r_mf    <= frag_last ? r_mfin : 1'b1;
            r_fin   <= 1'b0;
            r_oport <= r_port;
            r_last  <= frag_last;
        end
    end

    assign o_kind               = r_kind;
    assign o_frag_length        = r_len;
    assign o_frag_offset        = r_offo;
    assign o_more_fragments_out = r_mf;
    assign o_final_mark         = r_fin;
    assign o_out_port           = r_oport;
    assign o_last               = r_last;

endmodule

[rtl/ipv4_fragment_planner_core.sv]
// Top level of the IPv4 fragment planner: controller plus datapath.
//
//  channel   | direction | handshake               | contents
//  s_axis    | in        | tvalid/tready           | one datagram header per transfer
//  m_axis    | out       | tvalid/tready, tlast    | one result per transfer, kind in tuser
//  cfg       | in        | wr_en, no wait          | port_count
//
// A header is taken while the block is idle, classified in the next cycle, and its first
// result is presented in the cycle after. Each further fragment is presented in the cycle
// after the previous result transfer. The fragment walk steps one offset add per result.
// Reset (synchronous, active low) returns to idle with port_count = 4.
// A stalled result holds its fields; no new header is taken until the last transfer.
module ipv4_fragment_planner_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // datagram_length[15:0], header_length[21:16], link_mtu[37:22],
    // dont_fragment[38], more_fragments_in[39], egress_port[43:40], zero fill
    input  logic [ipv4fp_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // frag_length[15:0], frag_offset[31:16], more_fragments_out[32],
    // final_mark[33], out_port[37:34], zero fill
    output logic [ipv4fp_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // kind[2:0]
    output logic [ipv4fp_pkg::KIND_W-1:0]        o_m_axis_tuser,
    output logic                                 o_m_axis_tlast,
    input  logic                                 i_cfg_wr_en,
    input  logic [ipv4fp_pkg::PCNT_W-1:0]        i_cfg_wr_data
);

    ipv4fp_pkg::t_cmd    cmd;
    ipv4fp_pkg::t_status status;

    logic [ipv4fp_pkg::LEN_W-1:0]     frag_length;
    logic [ipv4fp_pkg::LEN_W-1:0]     frag_offset;
    logic                             more_fragments_out;
    logic                             final_mark;
    logic [ipv4fp_pkg::PORT_BITS-1:0] out_port;

    ipv4fp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    ipv4fp_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_status             (status),
        .i_cfg_wr_en          (i_cfg_wr_en),
        .i_cfg_wr_data        (i_cfg_wr_data),
        .i_datagram_length    (i_s_axis_tdata[ipv4fp_pkg::IN_TOT_LO +: ipv4fp_pkg::LEN_W]),
        .i_header_length      (i_s_axis_tdata[ipv4fp_pkg::IN_HDR_LO +: ipv4fp_pkg::HDR_W]),
        .i_link_mtu           (i_s_axis_tdata[ipv4fp_pkg::IN_MTU_LO +: ipv4fp_pkg::LEN_W]),
        .i_dont_fragment      (i_s_axis_tdata[ipv4fp_pkg::IN_DF_BIT]),
        .i_more_fragments_in  (i_s_axis_tdata[ipv4fp_pkg::IN_MF_BIT]),
        .i_egress_port        (i_s_axis_tdata[ipv4fp_pkg::IN_PRT_LO +: ipv4fp_pkg::PORT_BITS]),
        .o_kind               (o_m_axis_tuser),
        .o_frag_length        (frag_length),
        .o_frag_offset        (frag_offset),
        .o_more_fragments_out (more_fragments_out),
        .o_final_mark         (final_mark),
        .o_out_port           (out_port),
        .o_last               (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {{(ipv4fp_pkg::OUT_DATA_W - ipv4fp_pkg::OUT_USED_W){1'b0}},
                             out_port, final_mark, more_fragments_out,
                             frag_offset, frag_length};

endmodule

[rtl/ipv4fp_chk.sv]
// Port-level checker for the IPv4 fragment planner, bound to the top level.
module ipv4fp_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_axis_tvalid,
    input logic                              o_s_axis_tready,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [ipv4fp_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic [ipv4fp_pkg::KIND_W-1:0]     o_m_axis_tuser,
    input logic                              o_m_axis_tlast
);

    // a result waiting on the sink stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result changed");

    // no header is taken while results of the previous one are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_s_axis_tready)
        else $error("input ready while result pending");

    // a header transfer is followed by a classification cycle with no result
    a_eval_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> (!o_m_axis_tvalid && !o_s_axis_tready))
        else $error("no classification cycle after header transfer");

    // only a whole forward carries the final mark, and it is always alone
    a_final_whole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[33])
            |-> (o_m_axis_tuser == ipv4fp_pkg::KIND_WHOLE && o_m_axis_tlast))
        else $error("final mark on a result that is not a whole forward");

    // results other than fragments end the run at once
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != ipv4fp_pkg::KIND_FRAG) |-> o_m_axis_tlast)
        else $error("non-fragment result without tlast");

endmodule

bind ipv4_fragment_planner_core ipv4fp_chk u_ipv4fp_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
